// ----- hw/rtl/mft_pkg.sv -----
// shared constants and types for the multi-turn angle tracker
package mft_pkg;

	localparam int ANGLE_W = 13;
	localparam int TURN_W  = 16;
	localparam int TOTAL_W = 29;
	localparam int WORD_W  = 16;
	localparam int TEMP_W  = 8;

	localparam logic [ANGLE_W-1:0] THRESHOLD_RESET = 13'd4915;
	localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
	localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

	// per-item output of the unwrap logic
	typedef struct packed {
		logic signed [TURN_W-1:0]  turn_count;
		logic signed [TOTAL_W-1:0] unwrapped_angle;
	} unwrap_res_t;

endpackage

// ----- hw/rtl/mft_unwrap.sv -----
// turn counting state and unwrapped angle arithmetic
module mft_unwrap
	import mft_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [ANGLE_W-1:0] thr,
	output unwrap_res_t        res
);

	logic                       seen_q;
	logic [ANGLE_W-1:0]         start_q;
	logic [ANGLE_W-1:0]         prev_q;
	logic signed [TURN_W-1:0]   turns_q;

	logic [ANGLE_W-1:0]         start_eff;
	logic [ANGLE_W-1:0]         prev_eff;
	logic signed [TURN_W-1:0]   turns_base;
	logic signed [ANGLE_W+1:0]  jump;
	logic signed [ANGLE_W+1:0]  thr_ext;
	logic                       up;
	logic                       down;
	logic signed [TURN_W-1:0]   turns_up;
	logic signed [TURN_W-1:0]   turns_new;
	logic signed [TOTAL_W-1:0]  turns_ext;
	logic signed [TOTAL_W-1:0]  total;

	// first frame takes its own angle as start and previous
	assign start_eff  = seen_q ? start_q : angle;
	assign prev_eff   = seen_q ? prev_q  : angle;
	assign turns_base = seen_q ? turns_q : '0;

	assign jump    = $signed({2'b00, angle}) - $signed({2'b00, prev_eff});
	assign thr_ext = $signed({2'b00, thr});
	assign up      = (jump + thr_ext) <= 0;
	assign down    = jump >= thr_ext;

	// up step first, then down step, each saturating
	assign turns_up  = (up && turns_base != TURN_MAX) ? turns_base + 16'sd1 : turns_base;
	assign turns_new = (down && turns_up != TURN_MIN) ? turns_up - 16'sd1 : turns_up;

	// turns * 8191 as turns * 8192 - turns
	assign turns_ext = TOTAL_W'(turns_new);
	assign total     = (turns_ext <<< ANGLE_W) - turns_ext
		+ $signed({{(TOTAL_W-ANGLE_W){1'b0}}, angle})
		- $signed({{(TOTAL_W-ANGLE_W){1'b0}}, start_eff});

	assign res.turn_count      = turns_new;
	assign res.unwrapped_angle = total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			start_q <= '0;
			prev_q  <= '0;
			turns_q <= '0;
		end else if (advance) begin
			seen_q  <= 1'b1;
			start_q <= start_eff;
			prev_q  <= angle;
			turns_q <= turns_new;
		end
	end

`ifndef SYNTH
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(turns_q) && $stable(prev_q) && $stable(start_q))
		else $error("tracker state changed without an item");
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q && $stable(start_q))
		else $error("start angle changed after first frame");
	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && seen_q |=> (turns_q - $past(turns_q)) <= 16'sd1
			&& (turns_q - $past(turns_q)) >= -16'sd1)
		else $error("turn count moved by more than one");
`endif

endmodule

// ----- hw/rtl/motor_feedback_multiturn_tracker.sv -----
// top level of the multi-turn angle tracker for motor feedback frames
//
// usage notes
// - input channel: in_valid / in_stall carry one seven-byte feedback frame;
//   a transfer happens on a rising edge with in_valid high and in_stall low
// - output channel: out_valid / out_stall carry one result per frame: the
//   13-bit angle, raw speed, current and temperature, the saturating turn
//   count and the unwrapped angle
// - config channel: cfg_valid / cfg_ready write wrap_threshold; cfg_ready
//   is always high, write only while no frame is in flight
// - timing: the transfer edge loads the input register, and the frame moves
//   on into the result register, which drives out_valid, once it is free;
//   throughput one frame per cycle while the receiver does not stall, set by the single compare-and-add pass
// - the turn state updates as a frame moves into the result register, so
//   back-to-back frames see each other's effect in order
// - receiver stall: the result register holds, the input register fills,
//   then in_stall rises until the receiver takes the result
// - reset: threshold returns to 4915, the first frame after reset latches
//   the start angle and begins with zero turns
module motor_feedback_multiturn_tracker
	import mft_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	// config write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ANGLE_W-1:0]         wrap_threshold,

	// input frame
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [4:0]                 angle_high,
	input  logic [7:0]                 angle_low,
	input  logic [7:0]                 speed_high,
	input  logic [7:0]                 speed_low,
	input  logic [7:0]                 current_high,
	input  logic [7:0]                 current_low,
	input  logic [TEMP_W-1:0]          temperature_in,

	// result
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ANGLE_W-1:0]         angle_counts,
	output logic signed [WORD_W-1:0]   speed_rpm,
	output logic signed [WORD_W-1:0]   current_raw,
	output logic [TEMP_W-1:0]          temperature_out,
	output logic signed [TURN_W-1:0]   turn_count,
	output logic signed [TOTAL_W-1:0]  unwrapped_angle
);

	// threshold register, always writable
	logic [ANGLE_W-1:0] thr_q;

	// input stage
	logic               v_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic [WORD_W-1:0]  speed_s1;
	logic [WORD_W-1:0]  current_s1;
	logic [TEMP_W-1:0]  temp_s1;

	// result stage
	logic                      v_s2;
	logic [ANGLE_W-1:0]        angle_s2;
	logic [WORD_W-1:0]         speed_s2;
	logic [WORD_W-1:0]         current_s2;
	logic [TEMP_W-1:0]         temp_s2;
	logic signed [TURN_W-1:0]  turns_s2;
	logic signed [TOTAL_W-1:0] total_s2;

	logic        out_free;
	logic        advance;
	logic        in_take;
	unwrap_res_t res;

	assign cfg_ready = 1'b1;

	// result register is free when empty or being taken this cycle
	assign out_free = !v_s2 || !out_stall;
	assign advance  = v_s1 && out_free;
	// input register can load when empty or draining into the result register
	assign in_stall = v_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= wrap_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// frame bytes are packed into words on capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			angle_s1   <= {angle_high, angle_low};
			speed_s1   <= {speed_high, speed_low};
			current_s1 <= {current_high, current_low};
			temp_s1    <= temperature_in;
		end
	end

	mft_unwrap u_unwrap (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.angle  (angle_s1),
		.thr    (thr_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_s2   <= angle_s1;
			speed_s2   <= speed_s1;
			current_s2 <= current_s1;
			temp_s2    <= temp_s1;
			turns_s2   <= res.turn_count;
			total_s2   <= res.unwrapped_angle;
		end
	end

	assign out_valid       = v_s2;
	assign angle_counts    = angle_s2;
	assign speed_rpm       = $signed(speed_s2);
	assign current_raw     = $signed(current_s2);
	assign temperature_out = temp_s2;
	assign turn_count      = turns_s2;
	assign unwrapped_angle = total_s2;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2)
		else $error("input stalled with room in the pipeline");
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> v_s2 && angle_s2 == $past(angle_s1))
		else $error("frame lost moving into the result register");
	a_stalled_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle_counts)
			&& $stable(turn_count) && $stable(unwrapped_angle))
		else $error("stalled result changed");
`endif

endmodule
